FILE: design/ffha_pkg.sv
// Shared types and constants for the first-fit heap allocator.
// Holds the pool geometry, the command and status codes, and the word structs.
// No dependencies.
`timescale 1ns / 1ps

package ffha_pkg;

    localparam int POOL_WORDS = 1024;
    localparam int WORD_BYTES = 8;
    localparam int ADDR_W     = $clog2(POOL_WORDS);
    localparam int WB_SHIFT   = $clog2(WORD_BYTES);
    localparam int HDR_W      = 12;
    localparam int ALU_W      = 14;
    localparam int CFG_W      = 11;
    localparam int REQ_W      = 12;
    localparam int SIZE_W     = 14;
    localparam int BYTE_W     = 13;

    localparam logic [1:0] FN_FORMAT = 2'd0;
    localparam logic [1:0] FN_ALLOC  = 2'd1;
    localparam logic [1:0] FN_FREE   = 2'd2;
    localparam logic [1:0] FN_QUERY  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_ZERO  = 2'd2;

    typedef struct packed {
        logic [1:0]        func;
        logic [SIZE_W-1:0] size_bytes;
        logic [BYTE_W-1:0] handle;
    } req_word_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [BYTE_W-1:0] address;
        logic [BYTE_W-1:0] largest_bytes;
    } rsp_word_t;

    // y = a + (sub ? ~b : b) + inc
    typedef struct packed {
        logic       sub;
        logic [1:0] inc;
    } alu_op_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [HDR_W-1:0]  data;
    } hdr_wr_t;

endpackage

FILE: design/ffha_alu.sv
// Shared adder of the allocator: next-header pointers, merges, fit tests.
// Depends on ffha_pkg.
`timescale 1ns / 1ps

module ffha_alu (
    input  logic signed [ffha_pkg::ALU_W-1:0] a,
    input  logic signed [ffha_pkg::ALU_W-1:0] b,
    input  ffha_pkg::alu_op_t                 op,
    output logic signed [ffha_pkg::ALU_W-1:0] y
);
    import ffha_pkg::*;

    logic signed [ALU_W-1:0] opb;
    logic signed [ALU_W-1:0] incx;

    assign opb  = op.sub ? ~b : b;
    assign incx = $signed({{(ALU_W-2){1'b0}}, op.inc});
    assign y    = a + opb + incx;

endmodule

FILE: design/ffha_hdr_ram.sv
// Header store: one signed size per pool word, one write and one read port.
// Read data is registered. Depends on ffha_pkg.
`timescale 1ns / 1ps

module ffha_hdr_ram (
    input  logic                         clk,
    input  ffha_pkg::hdr_wr_t            wr,
    input  logic                         rd_en,
    input  logic [ffha_pkg::ADDR_W-1:0]  rd_addr,
    output logic [ffha_pkg::HDR_W-1:0]   rd_data
);
    import ffha_pkg::*;

    logic [HDR_W-1:0] mem_reg [POOL_WORDS];
    logic [HDR_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem_reg[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/first_fit_heap_allocator.sv
// Top level of the first-fit heap allocator: sequencer, request and result words.
// Depends on ffha_pkg, ffha_alu and ffha_hdr_ram.
`timescale 1ns / 1ps

// Usage
//   req_*  : command word (func, size_bytes, handle), valid/ready. One word is
//            taken only while the sequencer is idle; ready drops for the walk.
//   rsp_*  : result word (status, address, largest_bytes), valid/ready, one
//            per command, in order. A result sits in an output register, so
//            the next command is taken while the receiver stalls; a second
//            finished result waits in the sequencer until the register frees.
//   cfg_*  : pool_words write, always ready; used at the next format command.
// Walk
//   Format, a zero request and a bad-handle free need no walk. A walk
//   reads one header per visited block and one per free neighbour that
//   a merge absorbs, writes the merged, split or exact-fit headers, and
//   then loads the result. The single header read port and the one shared
//   adder set the pace; a fragmented pool takes longer. One command at a
//   time: ready returns the cycle after the result is loaded.
// Reset
//   rst_n is asynchronous. After it the block formats a 1024-word pool in
//   its init state (one free block and the end marker), then goes ready.
module first_fit_heap_allocator (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_ready,
    input  ffha_pkg::req_word_t          req_data,
    output logic                         rsp_valid,
    input  logic                         rsp_ready,
    output ffha_pkg::rsp_word_t          rsp_data,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [ffha_pkg::CFG_W-1:0]   cfg_data
);
    import ffha_pkg::*;

    localparam logic [3:0] S_INIT   = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_FMT    = 4'd2;
    localparam logic [3:0] S_RD     = 4'd3;
    localparam logic [3:0] S_LD     = 4'd4;
    localparam logic [3:0] S_EVAL   = 4'd5;
    localparam logic [3:0] S_SPLIT  = 4'd6;
    localparam logic [3:0] S_SPLIT2 = 4'd7;
    localparam logic [3:0] S_MNXT   = 4'd8;
    localparam logic [3:0] S_MRD    = 4'd9;
    localparam logic [3:0] S_MLD    = 4'd10;
    localparam logic [3:0] S_MEND   = 4'd11;
    localparam logic [3:0] S_DONE   = 4'd12;

    // Control state
    logic [3:0]        state_reg, state_next;
    logic              rsp_valid_reg, rsp_valid_next;
    logic [CFG_W-1:0]  pool_reg, pool_next;
    logic [ADDR_W-1:0] end_reg, end_next;
    logic [1:0]        func_reg, func_next;

    // Working payload
    logic [REQ_W-1:0]  req_reg, req_next;
    logic [ADDR_W-1:0] target_reg, target_next;
    logic [ADDR_W-1:0] b_reg, b_next;
    logic [ADDR_W-1:0] n_reg, n_next;
    logic [HDR_W-1:0]  s_reg, s_next;
    logic [ADDR_W-1:0] best_reg, best_next;
    logic [1:0]        status_reg, status_next;
    logic [BYTE_W-1:0] addr_reg, addr_next;
    rsp_word_t         rsp_data_reg, rsp_data_next;

    // Header store and shared adder
    hdr_wr_t           wr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [HDR_W-1:0]  rd_data;

    logic signed [ALU_W-1:0] alu_a, alu_b, alu_y;
    alu_op_t                 alu_op;
    logic                    alu_neg;

    // Operand extensions
    logic signed [ALU_W-1:0] b_x, s_x, req_x, rd_x, best_x;
    logic                    s_neg;

    // Command decode
    logic [SIZE_W:0]   size_sum;
    logic [REQ_W-1:0]  req_words;
    logic              handle_ok;
    logic [ADDR_W-1:0] handle_tgt;
    logic [CFG_W-1:0]  pool_clamp;
    logic [HDR_W-1:0]  fmt_size;
    logic [ADDR_W-1:0] fmt_end;

    ffha_hdr_ram u_hdr_ram (
        .clk     (clk),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ffha_alu u_alu (
        .a  (alu_a),
        .b  (alu_b),
        .op (alu_op),
        .y  (alu_y)
    );

    assign alu_neg = alu_y[ALU_W-1];

    assign b_x    = $signed({{(ALU_W-ADDR_W){1'b0}}, b_reg});
    assign s_x    = $signed({{(ALU_W-HDR_W){s_reg[HDR_W-1]}}, s_reg});
    assign req_x  = $signed({{(ALU_W-REQ_W){1'b0}}, req_reg});
    assign rd_x   = $signed({{(ALU_W-HDR_W){rd_data[HDR_W-1]}}, rd_data});
    assign best_x = $signed({{(ALU_W-ADDR_W){1'b0}}, best_reg});
    assign s_neg  = s_reg[HDR_W-1];

    // Round the byte request up to whole words
    assign size_sum  = {1'b0, req_data.size_bytes} + (SIZE_W+1)'(WORD_BYTES - 1);
    assign req_words = REQ_W'(size_sum >> WB_SHIFT);

    // A handle must be word-aligned and past the first header
    assign handle_ok  = (req_data.handle[WB_SHIFT-1:0] == '0) && (req_data.handle != '0);
    assign handle_tgt = ADDR_W'(req_data.handle >> WB_SHIFT) - ADDR_W'(1);

    // Saturate the configured pool size into the legal range
    always_comb
    begin
        if (pool_reg < CFG_W'(4))
        begin
            pool_clamp = CFG_W'(4);
        end
        else if (pool_reg > CFG_W'(POOL_WORDS))
        begin
            pool_clamp = CFG_W'(POOL_WORDS);
        end
        else
        begin
            pool_clamp = pool_reg;
        end
    end

    assign fmt_size = HDR_W'(pool_clamp - CFG_W'(2));
    assign fmt_end  = ADDR_W'(pool_clamp - CFG_W'(1));

    assign req_ready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg;
        pool_next      = pool_reg;
        end_next       = end_reg;
        func_next      = func_reg;
        req_next       = req_reg;
        target_next    = target_reg;
        b_next         = b_reg;
        n_next         = n_reg;
        s_next         = s_reg;
        best_next      = best_reg;
        status_next    = status_reg;
        addr_next      = addr_reg;
        rsp_data_next  = rsp_data_reg;

        wr      = '0;
        rd_en   = 1'b0;
        rd_addr = b_reg;

        // Default adder set-up: step to the next header, b + 1 + |s|
        alu_a      = b_x;
        alu_b      = s_x;
        alu_op.sub = s_neg;
        alu_op.inc = s_neg ? 2'd2 : 2'd1;

        // Drop the result once the receiver takes it
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        if (cfg_valid)
        begin
            pool_next = cfg_data;
        end

        unique case (state_reg)
            S_INIT:
            begin
                wr       = '{en: 1'b1, addr: '0, data: fmt_size};
                end_next = fmt_end;
                state_next = S_IDLE;
            end

            S_IDLE:
            begin
                if (req_valid)
                begin
                    func_next   = req_data.func;
                    status_next = ST_OK;
                    addr_next   = '0;
                    best_next   = '0;
                    b_next      = '0;
                    unique case (req_data.func)
                        FN_FORMAT:
                        begin
                            state_next = S_FMT;
                        end
                        FN_ALLOC:
                        begin
                            if (req_data.size_bytes == '0)
                            begin
                                status_next = ST_ZERO;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                req_next    = req_words;
                                status_next = ST_NOFIT;
                                state_next  = S_RD;
                            end
                        end
                        FN_FREE:
                        begin
                            target_next = handle_tgt;
                            state_next  = handle_ok ? S_RD : S_DONE;
                        end
                        default:
                        begin
                            state_next = S_RD;
                        end
                    endcase
                end
            end

            S_FMT:
            begin
                wr         = '{en: 1'b1, addr: '0, data: fmt_size};
                end_next   = fmt_end;
                state_next = S_DONE;
            end

            S_RD:
            begin
                // Stop at the end marker, or once a free passes its target
                if ((b_reg >= end_reg) || ((func_reg == FN_FREE) && (b_reg > target_reg)))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = b_reg;
                    state_next = S_LD;
                end
            end

            S_LD:
            begin
                s_next     = rd_data;
                state_next = S_EVAL;
            end

            S_EVAL:
            begin
                unique case (func_reg)
                    FN_ALLOC:
                    begin
                        if (s_neg)
                        begin
                            b_next     = alu_y[ADDR_W-1:0];
                            state_next = S_RD;
                        end
                        else
                        begin
                            // d = s - req - 1: -1 is an exact fit, >= 0 a split
                            alu_a      = s_x;
                            alu_b      = req_x;
                            alu_op.sub = 1'b1;
                            alu_op.inc = 2'd0;
                            if (alu_y == -ALU_W'(1))
                            begin
                                n_next     = b_reg;
                                state_next = S_SPLIT2;
                            end
                            else if (!alu_neg)
                            begin
                                wr         = '{en: 1'b1, addr: b_reg, data: alu_y[HDR_W-1:0]};
                                s_next     = alu_y[HDR_W-1:0];
                                state_next = S_SPLIT;
                            end
                            else
                            begin
                                state_next = S_MNXT;
                            end
                        end
                    end
                    FN_FREE:
                    begin
                        if (b_reg == target_reg)
                        begin
                            if (s_neg)
                            begin
                                alu_a      = '0;
                                alu_op.sub = 1'b1;
                                alu_op.inc = 2'd1;
                                wr = '{en: 1'b1, addr: b_reg, data: alu_y[HDR_W-1:0]};
                            end
                            state_next = S_DONE;
                        end
                        else
                        begin
                            b_next     = alu_y[ADDR_W-1:0];
                            state_next = S_RD;
                        end
                    end
                    FN_QUERY:
                    begin
                        if (s_neg)
                        begin
                            b_next     = alu_y[ADDR_W-1:0];
                            state_next = S_RD;
                        end
                        else
                        begin
                            state_next = S_MNXT;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_SPLIT:
            begin
                // Carve the allocation from the tail: n = b + 1 + remaining size
                n_next     = alu_y[ADDR_W-1:0];
                state_next = S_SPLIT2;
            end

            S_SPLIT2:
            begin
                alu_a       = '0;
                alu_b       = req_x;
                alu_op.sub  = 1'b1;
                alu_op.inc  = 2'd1;
                wr          = '{en: 1'b1, addr: n_reg, data: alu_y[HDR_W-1:0]};
                addr_next   = {ADDR_W'(n_reg + ADDR_W'(1)), {WB_SHIFT{1'b0}}};
                status_next = ST_OK;
                state_next  = S_DONE;
            end

            S_MNXT:
            begin
                n_next     = alu_y[ADDR_W-1:0];
                state_next = S_MRD;
            end

            S_MRD:
            begin
                // Allocation stops growing once the block reaches the request
                alu_a      = s_x;
                alu_b      = req_x;
                alu_op.sub = 1'b1;
                alu_op.inc = 2'd1;
                if ((n_reg >= end_reg) || ((func_reg == FN_ALLOC) && !alu_neg))
                begin
                    state_next = S_MEND;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = n_reg;
                    state_next = S_MLD;
                end
            end

            S_MLD:
            begin
                if (rd_data[HDR_W-1])
                begin
                    state_next = S_MEND;
                end
                else
                begin
                    alu_a      = s_x;
                    alu_b      = rd_x;
                    alu_op.sub = 1'b0;
                    alu_op.inc = 2'd1;
                    s_next     = alu_y[HDR_W-1:0];
                    state_next = S_MNXT;
                end
            end

            S_MEND:
            begin
                wr         = '{en: 1'b1, addr: b_reg, data: s_reg};
                alu_a      = s_x;
                alu_op.sub = 1'b1;
                alu_op.inc = 2'd1;
                if (func_reg == FN_QUERY)
                begin
                    alu_b = best_x;
                    if (!alu_neg && (alu_y != '0))
                    begin
                        best_next = s_reg[ADDR_W-1:0];
                    end
                    b_next     = n_reg;
                    state_next = S_RD;
                end
                else
                begin
                    alu_b = req_x;
                    if (alu_neg)
                    begin
                        b_next     = n_reg;
                        state_next = S_RD;
                    end
                    else
                    begin
                        state_next = S_EVAL;
                    end
                end
            end

            S_DONE:
            begin
                // Hold the result until the output register is free
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next              = 1'b1;
                    rsp_data_next.status        = status_reg;
                    rsp_data_next.address       = addr_reg;
                    rsp_data_next.largest_bytes = {best_reg, {WB_SHIFT{1'b0}}};
                    state_next                  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            rsp_valid_reg <= 1'b0;
            pool_reg      <= CFG_W'(POOL_WORDS);
            end_reg       <= ADDR_W'(POOL_WORDS - 1);
            func_reg      <= FN_FORMAT;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            pool_reg      <= pool_next;
            end_reg       <= end_next;
            func_reg      <= func_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        target_reg   <= target_next;
        b_reg        <= b_next;
        n_reg        <= n_next;
        s_reg        <= s_next;
        best_reg     <= best_next;
        status_reg   <= status_next;
        addr_reg     <= addr_next;
        rsp_data_reg <= rsp_data_next;
    end

    // A result appears only out of the completion state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside completion state");

    // Walk writes never reach the end marker or beyond
    assert property (@(posedge clk) disable iff (!rst_n)
        (wr.en && (state_reg != S_FMT) && (state_reg != S_INIT)) |-> (wr.addr < end_reg))
        else $error("header write past end of pool");

    // A non-zero address comes only with a successful allocation
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (rsp_data_reg.address != '0)) |-> (rsp_data_reg.status == ST_OK))
        else $error("address returned with failing status");

endmodule

FILE: bench/first_fit_heap_allocator_tb.sv
// Self-checking bench for first_fit_heap_allocator: format, allocate, free and query words
// are predicted by a shadow header chain and compared with every result word.
// Depends on ffha_pkg and the design sources of first_fit_heap_allocator.
`timescale 1ns / 1ps

module first_fit_heap_allocator_tb;

    import ffha_pkg::*;

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                req_valid  = 1'b0;
    logic                req_ready;
    req_word_t           req_data   = '0;
    logic                rsp_valid;
    logic                rsp_ready  = 1'b0;
    rsp_word_t           rsp_data;
    logic                cfg_valid  = 1'b0;
    logic                cfg_ready;
    logic [CFG_W-1:0]    cfg_data   = '0;

    // Shadow of the header store: one signed payload size per block start.
    int        hdr_shadow [POOL_WORDS];
    int        shadow_end;
    int        shadow_pool_cfg;
    int        live_handles [$];    // payload offsets the shadow holds as allocated

    req_word_t pending_cmds [$];    // command words waiting for the driver
    rsp_word_t owed_results [$];    // predicted result words, oldest first

    int        errors     = 0;
    int        cmds_taken = 0;
    int        send_gap   = 0;
    int        recv_gap   = 0;
    bit        gaps_on    = 1'b1;
    logic      rsp_hold   = 1'b0;

    always #5 clk = ~clk;

    first_fit_heap_allocator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Shadow allocator
    // ------------------------------------------------------------------

    // Header word of the block that follows block b.
    function automatic int chain_next(int b);
        int s;
        s = hdr_shadow[b];
        return b + 1 + ((s < 0) ? -s : s);
    endfunction

    // Grow free block b by swallowing the free blocks behind it, while it is
    // still below the limit. An allocated neighbour or the end stops it.
    function automatic void absorb_free(int b, int limit);
        int n;
        n = chain_next(b);
        while (hdr_shadow[b] < limit && n < shadow_end && hdr_shadow[n] >= 0)
        begin
            hdr_shadow[b] += 1 + hdr_shadow[n];
            n = chain_next(b);
        end
    endfunction

    // Lay out one free block over the whole pool; the size saturates to the
    // legal range here, not at the register write.
    function automatic void shadow_format();
        int p;
        p = shadow_pool_cfg;
        if (p < 4)
            p = 4;
        if (p > POOL_WORDS)
            p = POOL_WORDS;
        foreach (hdr_shadow[i])
            hdr_shadow[i] = 0;
        hdr_shadow[0] = p - 2;
        shadow_end    = p - 1;
        live_handles.delete();
    endfunction

    function automatic rsp_word_t predict_heap_cmd(req_word_t w);
        rsp_word_t r;
        int        want_words;
        int        b;
        int        s;
        int        n;
        int        target;
        int        best;
        int        idx;
        bit        placed;
        bit        scanning;
        r = '0;
        case (w.func)
            FN_FORMAT:
            begin
                shadow_format();
            end
            FN_ALLOC:
            begin
                if (w.size_bytes == 0)
                    r.status = ST_ZERO;
                else
                begin
                    want_words = (int'(w.size_bytes) + WORD_BYTES - 1) / WORD_BYTES;
                    r.status   = ST_NOFIT;
                    placed     = 1'b0;
                    b          = 0;
                    while (!placed && b < shadow_end)
                    begin
                        s = hdr_shadow[b];
                        if (s < 0)
                            b = chain_next(b);
                        else if (s == want_words)
                        begin
                            // exact fit: take the block whole
                            hdr_shadow[b] = -want_words;
                            r.address     = BYTE_W'((b + 1) * WORD_BYTES);
                            placed        = 1'b1;
                        end
                        else if (s >= want_words + 1)
                        begin
                            // split: carve the allocation from the tail
                            hdr_shadow[b] = s - (want_words + 1);
                            n             = chain_next(b);
                            hdr_shadow[n] = -want_words;
                            r.address     = BYTE_W'((n + 1) * WORD_BYTES);
                            placed        = 1'b1;
                        end
                        else
                        begin
                            // too small: merge forwards, then move on if still short
                            absorb_free(b, want_words);
                            if (hdr_shadow[b] < want_words)
                                b = chain_next(b);
                        end
                    end
                    if (placed)
                    begin
                        r.status = ST_OK;
                        live_handles.push_back(int'(r.address));
                    end
                end
            end
            FN_FREE:
            begin
                if (w.handle % WORD_BYTES == 0 && w.handle != 0)
                begin
                    target   = int'(w.handle) / WORD_BYTES - 1;
                    b        = 0;
                    scanning = 1'b1;
                    while (scanning && b < shadow_end && b <= target)
                    begin
                        if (b == target)
                        begin
                            if (hdr_shadow[b] < 0)
                            begin
                                hdr_shadow[b] = -hdr_shadow[b];
                                idx = -1;
                                foreach (live_handles[i])
                                    if (live_handles[i] == int'(w.handle))
                                        idx = i;
                                if (idx >= 0)
                                    live_handles.delete(idx);
                            end
                            scanning = 1'b0;
                        end
                        else
                            b = chain_next(b);
                    end
                end
            end
            default:
            begin
                // largest-free query: merge free runs only, never grow allocations
                b    = 0;
                best = 0;
                while (b < shadow_end)
                begin
                    if (hdr_shadow[b] >= 0)
                    begin
                        absorb_free(b, 32'h7FFF_FFFF);
                        if (hdr_shadow[b] > best)
                            best = hdr_shadow[b];
                    end
                    b = chain_next(b);
                end
                r.largest_bytes = BYTE_W'(best * WORD_BYTES);
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Mostly no gap, some short ones, a few long; none at all in quiet phases.
    function automatic int pick_gap();
        int roll;
        if (!gaps_on)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void queue_cmd(logic [1:0] func, int size_b, int handle_b);
        req_word_t w;
        w.func       = func;
        w.size_bytes = SIZE_W'(size_b);
        w.handle     = BYTE_W'(handle_b);
        pending_cmds.push_back(w);
    endfunction

    // Random command for a pool of pw words. Fields that the command ignores
    // carry noise. Most frees name a live payload; the rest are bad handles.
    function automatic req_word_t rand_cmd(int pw);
        req_word_t w;
        int        roll;
        int        sub;
        int        cap;
        int        nlive;
        w.size_bytes = SIZE_W'($urandom);
        w.handle     = BYTE_W'($urandom);
        nlive        = live_handles.size();
        cap          = pw * WORD_BYTES / 4;
        if (cap < 8)
            cap = 8;
        if (cap > 256)
            cap = 256;
        roll = $urandom_range(0, 99);
        sub  = $urandom_range(0, 99);
        if (roll < 42)
        begin
            w.func = FN_ALLOC;
            if (sub < 80)
                w.size_bytes = SIZE_W'($urandom_range(1, cap));
            else if (sub < 90)
                w.size_bytes = SIZE_W'($urandom_range(1, pw * WORD_BYTES));
            else if (sub < 96)
                w.size_bytes = SIZE_W'($urandom_range(0, 16383));
            else
                w.size_bytes = '0;
        end
        else if (roll < 80)
        begin
            w.func = FN_FREE;
            if (sub < 75 && nlive > 0)
                w.handle = BYTE_W'(live_handles[$urandom_range(0, nlive - 1)]);
            else if (sub < 82)
                w.handle = '0;
            else if (sub < 90 && nlive > 0)
                w.handle = BYTE_W'(live_handles[$urandom_range(0, nlive - 1)]
                                   + $urandom_range(1, 15));
            else
                w.handle = BYTE_W'($urandom_range(0, 8191));
        end
        else if (roll < 97)
            w.func = FN_QUERY;
        else
            w.func = FN_FORMAT;
        return w;
    endfunction

    // Idle means: nothing queued, nothing offered, nothing owed.
    task automatic wait_drained(int settle);
        @(negedge clk);
        while (pending_cmds.size() != 0 || req_valid || owed_results.size() != 0)
            @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    task automatic write_pool_words(int v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= CFG_W'(v);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid       <= 1'b0;
        shadow_pool_cfg  = v & 32'h7FF;
    endtask

    // ------------------------------------------------------------------
    // Command driver: offer words from the pending queue, hold each one
    // until taken, and predict its result at the accepting edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : cmd_driver
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            send_gap  <= 0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                owed_results.push_back(predict_heap_cmd(req_data));
                cmds_taken <= cmds_taken + 1;
            end
            if (!req_valid || req_ready)
            begin
                if (send_gap > 0)
                begin
                    req_valid <= 1'b0;
                    send_gap  <= send_gap - 1;
                end
                else if (pending_cmds.size() > 0)
                begin
                    req_data  <= pending_cmds.pop_front();
                    req_valid <= 1'b1;
                    send_gap  <= pick_gap();
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: stall at random, check every taken word against the
    // oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : rsp_monitor
        rsp_word_t want;
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            recv_gap  <= 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (owed_results.size() == 0)
                begin
                    $error("result word with nothing outstanding: %h", rsp_data);
                    errors++;
                end
                else
                begin
                    want = owed_results.pop_front();
                    if (rsp_data.status !== want.status)
                    begin
                        $error("status expected %0d got %0d", want.status, rsp_data.status);
                        errors++;
                    end
                    if (rsp_data.address !== want.address)
                    begin
                        $error("address expected %0d got %0d",
                               want.address, rsp_data.address);
                        errors++;
                    end
                    if (rsp_data.largest_bytes !== want.largest_bytes)
                    begin
                        $error("largest_bytes expected %0d got %0d",
                               want.largest_bytes, rsp_data.largest_bytes);
                        errors++;
                    end
                end
            end
            if (rsp_hold)
                rsp_ready <= 1'b0;
            else if (recv_gap > 0)
            begin
                rsp_ready <= 1'b0;
                recv_gap  <= recv_gap - 1;
            end
            else
            begin
                rsp_ready <= 1'b1;
                recv_gap  <= pick_gap();
            end
        end
    end

    // Back-pressure: once well into the run, refuse results for a long
    // stretch so the output register and the sequencer both fill and the
    // command side stalls while the driver keeps offering.
    initial
    begin : rsp_holdoff
        int n;
        wait (cmds_taken == 150);
        @(posedge clk);
        rsp_hold <= 1'b1;
        for (n = 0; n < 400; n++)
            @(posedge clk);
        rsp_hold <= 1'b0;
    end

    // Hang guard, far beyond the slowest legal run.
    initial
    begin : watchdog
        #200_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sequence: reset, directed words against the reset pool, then random
    // phases, each opened by a pool_words write and a format.
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int pool_plan [9];
        int gen_pw;
        int k;
        int i;
        pool_plan = '{0, 4, 2047, 5, 16, 1024, 40, 300, 0};
        pool_plan[8] = $urandom_range(4, 1023);

        shadow_pool_cfg = 1024;
        shadow_format();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Reset pool: one free block of 1022 words at word 0, end at 1023.
        queue_cmd(FN_QUERY, 0, 0);
        queue_cmd(FN_ALLOC, 0, 8191);      // zero request
        queue_cmd(FN_ALLOC, 1, 0);         // rounds up to one word, tail split
        queue_cmd(FN_ALLOC, 8, 0);
        queue_cmd(FN_ALLOC, 9, 0);         // rounds up to two words
        queue_cmd(FN_ALLOC, 16383, 0);     // too large for any pool
        queue_cmd(FN_FREE, 0, 0);          // zero handle
        queue_cmd(FN_FREE, 0, 8191);       // misaligned handle
        queue_cmd(FN_FREE, 0, 8184);       // aligned, but inside a payload
        queue_cmd(FN_FREE, 0, 8160);
        queue_cmd(FN_FREE, 0, 8160);       // double free
        queue_cmd(FN_FREE, 0, 8176);
        queue_cmd(FN_QUERY, 0, 0);         // merges the two freed neighbours
        queue_cmd(FN_ALLOC, 8120, 0);      // exact fit on the first block
        queue_cmd(FN_ALLOC, 24, 0);        // exact fit on the merged block
        queue_cmd(FN_FREE, 0, 8);
        queue_cmd(FN_FREE, 0, 8136);
        queue_cmd(FN_ALLOC, 8144, 0);      // fits only after a forward merge
        queue_cmd(FN_ALLOC, 8192, 0);
        queue_cmd(FN_QUERY, 0, 0);         // nothing free at all
        queue_cmd(FN_FORMAT, 0, 0);
        queue_cmd(FN_ALLOC, 8, 0);
        queue_cmd(FN_ALLOC, 8, 0);
        queue_cmd(FN_FREE, 0, 8176);
        queue_cmd(FN_FREE, 0, 8160);
        queue_cmd(FN_ALLOC, 16383, 0);     // fails, but the merges it made stay
        queue_cmd(FN_QUERY, 0, 0);

        for (k = 0; k < 9; k++)
        begin
            wait_drained(4);
            gaps_on = !(k == 3 || k == 6);
            write_pool_words(pool_plan[k]);
            gen_pw = (pool_plan[k] & 32'h7FF);
            if (gen_pw < 4)
                gen_pw = 4;
            if (gen_pw > POOL_WORDS)
                gen_pw = POOL_WORDS;
            queue_cmd(FN_FORMAT, $urandom_range(0, 16383), $urandom_range(0, 8191));
            // Keep the queue shallow so frees pick handles that are still live.
            for (i = 0; i < 59; i++)
            begin
                @(negedge clk);
                while (pending_cmds.size() > 1)
                    @(negedge clk);
                pending_cmds.push_back(rand_cmd(gen_pw));
            end
        end

        // Drain, then give a stray result time to show.
        wait_drained(0);
        gaps_on = 1'b1;
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: first_fit_heap_allocator.f
design/ffha_pkg.sv
design/ffha_alu.sv
design/ffha_hdr_ram.sv
design/first_fit_heap_allocator.sv
bench/first_fit_heap_allocator_tb.sv
